// File: design/ciu_pkg.sv
// shared types and constants for the css identifier unescaper
`timescale 1ns / 1ps

package ciu_pkg;

   localparam int CodeInWidth  = 21;
   localparam int CodeOutWidth = 24;
   localparam int DigitWidth   = 3;
   localparam int MaxDigits    = 6;
   localparam int QueueDepth   = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   localparam logic [CodeInWidth-1:0] ChDash   = CodeInWidth'(8'h2d);
   localparam logic [CodeInWidth-1:0] ChUnder  = CodeInWidth'(8'h5f);
   localparam logic [CodeInWidth-1:0] ChBslash = CodeInWidth'(8'h5c);
   localparam logic [CodeInWidth-1:0] ChSpace  = CodeInWidth'(8'h20);
   localparam logic [CodeInWidth-1:0] ChTab    = CodeInWidth'(8'h09);
   localparam logic [CodeInWidth-1:0] ChLf     = CodeInWidth'(8'h0a);
   localparam logic [CodeInWidth-1:0] ChFf     = CodeInWidth'(8'h0c);
   localparam logic [CodeInWidth-1:0] ChCr     = CodeInWidth'(8'h0d);
   localparam logic [CodeInWidth-1:0] ChDig0   = CodeInWidth'(8'h30);
   localparam logic [CodeInWidth-1:0] ChDig9   = CodeInWidth'(8'h39);
   localparam logic [CodeInWidth-1:0] ChLowA   = CodeInWidth'(8'h61);
   localparam logic [CodeInWidth-1:0] ChLowF   = CodeInWidth'(8'h66);
   localparam logic [CodeInWidth-1:0] ChLowZ   = CodeInWidth'(8'h7a);
   localparam logic [CodeInWidth-1:0] ChUpA    = CodeInWidth'(8'h41);
   localparam logic [CodeInWidth-1:0] ChUpF    = CodeInWidth'(8'h46);
   localparam logic [CodeInWidth-1:0] ChUpZ    = CodeInWidth'(8'h5a);

   typedef enum logic [2:0] {
      PH_FIRST    = 3'd0,
      PH_START    = 3'd1,
      PH_MID      = 3'd2,
      PH_ESC      = 3'd3,
      PH_AFTER    = 3'd4,
      PH_AFTER_CR = 3'd5
   } phase_type;

   typedef struct packed {
      logic [CodeOutWidth-1:0] code;
      logic                    valid;
      logic                    last;
   } rsp_item_type;

   typedef struct packed {
      rsp_item_type item0;
      rsp_item_type item1;
      logic [1:0]   count;
   } step_out_type;

endpackage

// File: design/ciu_step.sv
// per-character decode step with phase and escape accumulator
`timescale 1ns / 1ps

module ciu_step
   import ciu_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [CodeInWidth-1:0] code_point,
   input  logic                   last_char,
   output step_out_type           step_out
);

   phase_type                phase_ff, phase_in, phase_nx;
   logic [CodeOutWidth-1:0]  esc_ff, esc_in, esc_nx;
   logic [DigitWidth-1:0]    dcnt_ff, dcnt_in, dcnt_nx;
   logic [DigitWidth-1:0]    dcnt_inc;
   logic [CodeOutWidth-1:0]  esc_shift;
   logic [CodeOutWidth-1:0]  c_ext;

   logic is_dash, is_bslash, is_alpha, is_digit, is_name, is_ws, is_cr, is_lf;
   logic is_hex_lo, is_hex_up;
   logic [3:0] hex_val;

   logic [1:0]              cnt;
   logic [CodeOutWidth-1:0] e0, e1;

   assign c_ext     = CodeOutWidth'(code_point);
   assign is_dash   = (code_point == ChDash);
   assign is_bslash = (code_point == ChBslash);
   assign is_digit  = (code_point >= ChDig0) && (code_point <= ChDig9);
   assign is_alpha  = (code_point == ChUnder)
                    || ((code_point >= ChLowA) && (code_point <= ChLowZ))
                    || ((code_point >= ChUpA) && (code_point <= ChUpZ));
   assign is_name   = is_alpha || is_digit || is_dash;
   assign is_ws     = (code_point == ChSpace) || (code_point == ChTab)
                    || (code_point == ChLf) || (code_point == ChFf);
   assign is_cr     = (code_point == ChCr);
   assign is_lf     = (code_point == ChLf);
   assign is_hex_lo = (code_point >= ChLowA) && (code_point <= ChLowF);
   assign is_hex_up = (code_point >= ChUpA) && (code_point <= ChUpF);
   assign hex_val   = is_digit ? code_point[3:0] : code_point[3:0] + 4'd9;
   assign dcnt_inc  = dcnt_ff + DigitWidth'(1);
   assign esc_shift = {esc_ff[CodeOutWidth-5:0], hex_val};

   // character decision for one transaction
   always_comb begin
      phase_nx = phase_ff;
      esc_nx   = esc_ff;
      dcnt_nx  = dcnt_ff;
      cnt      = 2'd0;
      e0       = '0;
      e1       = '0;
      unique case (phase_ff)
         PH_FIRST, PH_START: begin
            if (phase_ff == PH_FIRST && is_dash) begin
               e0       = c_ext;
               cnt      = 2'd1;
               phase_nx = PH_START;
            end else if (is_bslash) begin
               phase_nx = PH_ESC;
               esc_nx   = '0;
               dcnt_nx  = '0;
            end else begin
               if (is_alpha) begin
                  e0  = c_ext;
                  cnt = 2'd1;
               end
               phase_nx = PH_MID;
            end
         end
         PH_ESC: begin
            if (is_digit || is_hex_lo || is_hex_up) begin
               esc_nx  = esc_shift;
               dcnt_nx = dcnt_inc;
               if (dcnt_inc >= DigitWidth'(MaxDigits)) begin
                  e0       = esc_shift;
                  cnt      = 2'd1;
                  phase_nx = PH_AFTER;
               end
            end else begin
               e0  = esc_ff;
               cnt = 2'd1;
               if (is_ws) begin
                  phase_nx = PH_MID;
               end else if (is_cr) begin
                  phase_nx = PH_AFTER_CR;
               end else if (is_bslash) begin
                  phase_nx = PH_ESC;
                  esc_nx   = '0;
                  dcnt_nx  = '0;
               end else begin
                  if (is_name) begin
                     e1  = c_ext;
                     cnt = 2'd2;
                  end
                  phase_nx = PH_MID;
               end
            end
         end
         PH_AFTER: begin
            if (is_ws) begin
               phase_nx = PH_MID;
            end else if (is_cr) begin
               phase_nx = PH_AFTER_CR;
            end else if (is_bslash) begin
               phase_nx = PH_ESC;
               esc_nx   = '0;
               dcnt_nx  = '0;
            end else begin
               if (is_name) begin
                  e0  = c_ext;
                  cnt = 2'd1;
               end
               phase_nx = PH_MID;
            end
         end
         PH_AFTER_CR: begin
            if (is_lf) begin
               phase_nx = PH_MID;
            end else if (is_bslash) begin
               phase_nx = PH_ESC;
               esc_nx   = '0;
               dcnt_nx  = '0;
            end else begin
               if (is_name) begin
                  e0  = c_ext;
                  cnt = 2'd1;
               end
               phase_nx = PH_MID;
            end
         end
         default: begin
            if (is_bslash) begin
               phase_nx = PH_ESC;
               esc_nx   = '0;
               dcnt_nx  = '0;
            end else begin
               if (is_name) begin
                  e0  = c_ext;
                  cnt = 2'd1;
               end
               phase_nx = PH_MID;
            end
         end
      endcase
   end

   // end of identifier: flush escape, mark end, return to reset state
   always_comb begin
      step_out.item0 = '{code: e0, valid: 1'b1, last: 1'b0};
      step_out.item1 = '{code: e1, valid: 1'b1, last: 1'b0};
      step_out.count = cnt;
      phase_in       = phase_nx;
      esc_in         = esc_nx;
      dcnt_in        = dcnt_nx;
      if (last_char) begin
         if (phase_nx == PH_ESC) begin
            if (cnt == 2'd0) begin
               step_out.item0.code = esc_nx;
               step_out.count      = 2'd1;
            end else begin
               step_out.item1.code = esc_nx;
               step_out.count      = 2'd2;
            end
         end
         if (step_out.count == 2'd0) begin
            step_out.item0 = '{code: '0, valid: 1'b0, last: 1'b1};
            step_out.count = 2'd1;
         end else if (step_out.count == 2'd1) begin
            step_out.item0.last = 1'b1;
         end else begin
            step_out.item1.last = 1'b1;
         end
         phase_in = PH_FIRST;
         esc_in   = '0;
         dcnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         esc_ff   <= '0;
         dcnt_ff  <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         esc_ff   <= esc_in;
         dcnt_ff  <= dcnt_in;
      end
   end

endmodule

// File: design/ciu_queue.sv
// result queue: up to two results in per cycle, one out if ready
`timescale 1ns / 1ps

module ciu_queue
   import ciu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  step_out_type push_data,
   output logic         room,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   rsp_item_type                mem_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]    wr_ff, wr_in;
   logic [QueuePtrWidth-1:0]    rd_ff, rd_in;
   logic [QueueCntWidth-1:0]    cnt_ff, cnt_in;
   logic [QueueCntWidth-1:0]    push_n;
   logic                        pop;

   assign room      = (cnt_ff <= QueueCntWidth'(QueueDepth - 2));
   assign out_valid = (cnt_ff != '0);
   assign out_item  = mem_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   assign push_n    = push ? QueueCntWidth'(push_data.count) : '0;
   assign wr_in     = wr_ff + QueuePtrWidth'(push_n);
   assign rd_in     = rd_ff + QueuePtrWidth'(pop);
   assign cnt_in    = cnt_ff + push_n - QueueCntWidth'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && push_data.count != 2'd0) begin
         mem_ff[wr_ff] <= push_data.item0;
      end
      if (push && push_data.count == 2'd2) begin
         mem_ff[wr_ff + QueuePtrWidth'(1)] <= push_data.item1;
      end
   end

endmodule

// File: design/css_identifier_unescape_top.sv
// css identifier unescaper: escaped code points in, unescaped code points out
// path: input register, then step logic, then result queue, to the rsp side
// throughput: one input transaction per cycle while the result queue has room;
//   a character that yields two results gives them one after another on the rsp side
// reset: synchronous active-high reset empties the input register and result
//   queue and returns the decoder to the first character position
`timescale 1ns / 1ps

module css_identifier_unescape_top
   import ciu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [20:0] code_point, [23:21] zero
   input  logic        req_tlast,   // last_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [23:0] out_code
   output logic        rsp_tuser,   // code_valid
   output logic        rsp_tlast    // ident_end
);

   logic                   in_valid_ff, in_valid_in;
   logic [CodeInWidth-1:0] in_code_ff;
   logic                   in_last_ff;
   logic                   room;
   logic                   step_fire;
   logic                   req_take;
   step_out_type           step_out;
   rsp_item_type           out_item;

   assign step_fire   = in_valid_ff && room;
   assign req_tready  = !in_valid_ff || step_fire;
   assign req_take    = req_tvalid && req_tready;
   assign in_valid_in = req_take || (in_valid_ff && !step_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_code_ff <= req_tdata[CodeInWidth-1:0];
         in_last_ff <= req_tlast;
      end
   end

   ciu_step u_step (
      .clock      (clock),
      .reset      (reset),
      .fire       (step_fire),
      .code_point (in_code_ff),
      .last_char  (in_last_ff),
      .step_out   (step_out)
   );

   ciu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step_fire),
      .push_data (step_out),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = out_item.code;
   assign rsp_tuser = out_item.valid;
   assign rsp_tlast = out_item.last;

endmodule
